// ===== hw/rtl/qrs_pkg.sv =====
// quadratic root solver: shared types, widths and codes
// used by every module of the solver, depends on nothing
`timescale 1ns / 1ps
package qrs_pkg;

  localparam int QRS_COEF_WIDTH = 32;
  localparam int QRS_FRAC_BITS  = 16;

  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_ONE      = 2'd1;
  localparam logic [1:0] KIND_TWO      = 2'd2;
  localparam logic [1:0] KIND_INFINITE = 2'd3;

  localparam logic [1:0] REG_COEFF_EPS = 2'd0;
  localparam logic [1:0] REG_DISC_EPS  = 2'd1;
  localparam logic [1:0] REG_ROOT_EPS  = 2'd2;

  typedef struct packed {
    logic signed [QRS_COEF_WIDTH-1:0] coef_quad;
    logic signed [QRS_COEF_WIDTH-1:0] coef_lin;
    logic signed [QRS_COEF_WIDTH-1:0] coef_const;
  } qrs_coef_t;

  typedef struct packed {
    logic [1:0]                       root_kind;
    logic signed [QRS_COEF_WIDTH-1:0] root_low;
    logic signed [QRS_COEF_WIDTH-1:0] root_high;
    logic                             overflow;
  } qrs_root_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       div_on;
    logic       dsign;
    logic       dz;
    logic       neg1;
    logic       neg2;
    logic       nz1;
    logic       nz2;
  } qrs_side_t;

  function automatic logic [QRS_COEF_WIDTH-1:0] qrs_mag(input logic [QRS_COEF_WIDTH-1:0] x);
    qrs_mag = x[QRS_COEF_WIDTH-1] ? (~x + 1'b1) : x;
  endfunction

endpackage

// ===== hw/rtl/qrs_sqrt_cell.sv =====
// quadratic root solver: one bit of the restoring square root chain
// depends on qrs_pkg
`timescale 1ns / 1ps
module qrs_sqrt_cell #(
  parameter int DW = 66,
  parameter int RW = 33,
  parameter int AW = 68,
  parameter int K  = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               v_in,
  input  qrs_pkg::qrs_side_t side_in,
  input  logic [DW-1:0]      rem_in,
  input  logic [RW-1:0]      r_in,
  input  logic [AW-1:0]      aux_in,
  output logic               v_out,
  output qrs_pkg::qrs_side_t side_out,
  output logic [DW-1:0]      rem_out,
  output logic [RW-1:0]      r_out,
  output logic [AW-1:0]      aux_out
);
  import qrs_pkg::*;

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        fits;

  always_comb begin
    trial = ({{(DW+1-RW){1'b0}}, r_in} << (K+1)) + ({{DW{1'b0}}, 1'b1} << (2*K));
    diff  = {1'b0, rem_in} - trial;
    fits  = {1'b0, rem_in} >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      aux_out  <= aux_in;
      rem_out  <= fits ? diff[DW-1:0] : rem_in;
      r_out    <= fits ? (r_in | ({{(RW-1){1'b0}}, 1'b1} << K)) : r_in;
    end
  end

endmodule

// ===== hw/rtl/qrs_div_cell.sv =====
// quadratic root solver: one quotient bit of the two-lane long division chain
// depends on qrs_pkg
`timescale 1ns / 1ps
module qrs_div_cell #(
  parameter int NB  = 50,
  parameter int RMW = 34,
  parameter int DMW = 33
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               v_in,
  input  qrs_pkg::qrs_side_t side_in,
  input  logic [DMW-1:0]     dm_in,
  input  logic [NB-1:0]      num1_in,
  input  logic [NB-1:0]      num2_in,
  input  logic [RMW-1:0]     rem1_in,
  input  logic [RMW-1:0]     rem2_in,
  input  logic [NB-1:0]      q1_in,
  input  logic [NB-1:0]      q2_in,
  output logic               v_out,
  output qrs_pkg::qrs_side_t side_out,
  output logic [DMW-1:0]     dm_out,
  output logic [NB-1:0]      num1_out,
  output logic [NB-1:0]      num2_out,
  output logic [RMW-1:0]     rem1_out,
  output logic [RMW-1:0]     rem2_out,
  output logic [NB-1:0]      q1_out,
  output logic [NB-1:0]      q2_out
);
  import qrs_pkg::*;

  logic [RMW-1:0] t1, t2, dmx;
  logic           ge1, ge2;

  always_comb begin
    dmx = {{(RMW-DMW){1'b0}}, dm_in};
    t1  = {rem1_in[RMW-2:0], num1_in[NB-1]};
    t2  = {rem2_in[RMW-2:0], num2_in[NB-1]};
    ge1 = t1 >= dmx;
    ge2 = t2 >= dmx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      dm_out   <= dm_in;
      num1_out <= {num1_in[NB-2:0], 1'b0};
      num2_out <= {num2_in[NB-2:0], 1'b0};
      rem1_out <= ge1 ? (t1 - dmx) : t1;
      rem2_out <= ge2 ? (t2 - dmx) : t2;
      q1_out   <= {q1_in[NB-2:0], ge1};
      q2_out   <= {q2_in[NB-2:0], ge2};
    end
  end

endmodule

// ===== hw/rtl/quadratic_root_solver_core.sv =====
// quadratic root solver: top level, input split, products, discriminant,
// square root and division chains, saturation and apb registers
// depends on qrs_pkg, qrs_sqrt_cell, qrs_div_cell
//
// usage: coefficient words (a, b, c in signed fixed point) enter on the
// coef channel, one root word per coefficient word leaves on the root
// channel in the same order. registers sit on the apb port at byte
// addresses 0, 8 and 16, 64-bit data. the user must see that they are
// written only while the block is idle; the block does not enforce it.
// pipeline: 3 front stages, one square root cell per root bit, one stage
// forming numerators, one division cell per quotient bit, one output
// stage; with FRAC_BITS the division chain is 34+FRAC_BITS cells long.
// throughput: one word per cycle unless the receiver stalls, set by the
// single shared pipeline. a stalled receiver freezes the whole pipeline
// and drops coef_ready until the output word is taken.
// reset clears all valid bits and loads the register reset values.
`timescale 1ns / 1ps
module quadratic_root_solver_core #(
  parameter int FRAC_BITS = qrs_pkg::QRS_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              coef_valid,
  output logic              coef_ready,
  input  qrs_pkg::qrs_coef_t coef,
  output logic              root_valid,
  input  logic              root_ready,
  output qrs_pkg::qrs_root_t root,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);
  import qrs_pkg::*;

  localparam int W   = QRS_COEF_WIDTH;
  localparam int DW  = 2*W + 2;
  localparam int RW  = W + 1;
  localparam int NW  = W + 3;
  localparam int MW  = W + 2;
  localparam int NB  = MW + FRAC_BITS;
  localparam int DMW = W + 1;
  localparam int RMW = W + 2;
  localparam int AW  = NW + DMW;

  // registers
  logic [30:0] coeff_eps;
  logic [61:0] disc_eps;
  logic [30:0] root_eps;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_eps <= 31'd1;
      disc_eps  <= 62'd1;
      root_eps  <= 31'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:3])
        REG_COEFF_EPS: coeff_eps <= pwdata[30:0];
        REG_DISC_EPS:  disc_eps  <= pwdata[61:0];
        REG_ROOT_EPS:  root_eps  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_COEFF_EPS: prdata = {33'd0, coeff_eps};
      REG_DISC_EPS:  prdata = {2'd0, disc_eps};
      REG_ROOT_EPS:  prdata = {33'd0, root_eps};
      default:       prdata = 64'd0;
    endcase
  end

  logic adv;
  assign adv        = !root_valid || root_ready;
  assign coef_ready = adv;

  // stage 1: magnitudes and near-zero flags
  logic         v1;
  logic [W-1:0] am1, bm1, cm1;
  logic         an1, bn1, cn1, az1, bz1, cz1;
  logic [W-1:0] am_c, bm_c, cm_c;

  always_comb begin
    am_c = qrs_mag(coef.coef_quad);
    bm_c = qrs_mag(coef.coef_lin);
    cm_c = qrs_mag(coef.coef_const);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= coef_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      am1 <= am_c;
      bm1 <= bm_c;
      cm1 <= cm_c;
      an1 <= coef.coef_quad[W-1];
      bn1 <= coef.coef_lin[W-1];
      cn1 <= coef.coef_const[W-1];
      az1 <= am_c < {{(W-31){1'b0}}, coeff_eps};
      bz1 <= bm_c < {{(W-31){1'b0}}, coeff_eps};
      cz1 <= cm_c < {{(W-31){1'b0}}, coeff_eps};
    end
  end

  // stage 2: products
  logic           v2;
  logic [2*W-1:0] bb2, ac2;
  logic [W-1:0]   am2, bm2, cm2;
  logic           an2, bn2, cn2, az2, bz2, cz2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bb2 <= bm1 * bm1;
      ac2 <= am1 * cm1;
      am2 <= am1;
      bm2 <= bm1;
      cm2 <= cm1;
      an2 <= an1;
      bn2 <= bn1;
      cn2 <= cn1;
      az2 <= az1;
      bz2 <= bz1;
      cz2 <= cz1;
    end
  end

  // stage 3: discriminant and classification
  logic [DW-1:0]  bbx, ac4, dsum, dsq_c;
  logic           dneg, disc_small;
  logic [NW-1:0]  nb_c, bvx, cvx;
  logic [DMW-1:0] dm_c;
  qrs_side_t      side_c;

  always_comb begin
    bbx  = {2'b00, bb2};
    ac4  = {ac2, 2'b00};
    dneg = 1'b0;
    if (an2 != cn2) begin
      dsum = bbx + ac4;
    end else if (bbx >= ac4) begin
      dsum = bbx - ac4;
    end else begin
      dsum = ac4 - bbx;
      dneg = 1'b1;
    end
    disc_small = dsum <= {{(DW-62){1'b0}}, disc_eps};
    bvx   = bn2 ? {3'b000, bm2} : (~{3'b000, bm2} + 1'b1);
    cvx   = cn2 ? {3'b000, cm2} : (~{3'b000, cm2} + 1'b1);
    side_c       = '0;
    side_c.dsign = an2;
    nb_c         = bvx;
    dm_c         = {am2, 1'b0};
    dsq_c        = '0;
    if (az2) begin
      if (bz2) begin
        side_c.kind = cz2 ? KIND_INFINITE : KIND_NONE;
      end else begin
        side_c.kind   = KIND_ONE;
        side_c.div_on = 1'b1;
        side_c.dsign  = bn2;
        nb_c          = cvx;
        dm_c          = {1'b0, bm2};
      end
    end else if (disc_small) begin
      side_c.kind   = KIND_ONE;
      side_c.div_on = 1'b1;
    end else if (dneg) begin
      side_c.kind = KIND_NONE;
    end else begin
      side_c.kind   = KIND_TWO;
      side_c.div_on = 1'b1;
      dsq_c         = dsum;
    end
    side_c.dz = dm_c == '0;
  end

  logic          sv [RW+1];
  qrs_side_t     sside [RW+1];
  logic [DW-1:0] srem [RW+1];
  logic [RW-1:0] sr [RW+1];
  logic [AW-1:0] saux [RW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sside[0] <= side_c;
      srem[0]  <= dsq_c;
      sr[0]    <= '0;
      saux[0]  <= {nb_c, dm_c};
    end
  end

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    qrs_sqrt_cell #(.DW(DW), .RW(RW), .AW(AW), .K(RW-1-i)) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .v_in(sv[i]), .side_in(sside[i]), .rem_in(srem[i]), .r_in(sr[i]), .aux_in(saux[i]),
      .v_out(sv[i+1]), .side_out(sside[i+1]), .rem_out(srem[i+1]), .r_out(sr[i+1]),
      .aux_out(saux[i+1])
    );
  end

  // numerators -b -/+ sqrt(d)
  logic [NW-1:0]  nb_p, sx, n1, n2, n1m, n2m;
  logic [DMW-1:0] dm_p;
  qrs_side_t      side_p;

  always_comb begin
    nb_p   = saux[RW][AW-1:DMW];
    dm_p   = saux[RW][DMW-1:0];
    sx     = {2'b00, sr[RW]};
    n1     = nb_p - sx;
    n2     = nb_p + sx;
    n1m    = n1[NW-1] ? (~n1 + 1'b1) : n1;
    n2m    = n2[NW-1] ? (~n2 + 1'b1) : n2;
    side_p      = sside[RW];
    side_p.neg1 = n1[NW-1];
    side_p.neg2 = n2[NW-1];
    side_p.nz1  = n1 != '0;
    side_p.nz2  = n2 != '0;
  end

  logic           dv [NB+1];
  qrs_side_t      dside [NB+1];
  logic [DMW-1:0] ddm [NB+1];
  logic [NB-1:0]  dnum1 [NB+1];
  logic [NB-1:0]  dnum2 [NB+1];
  logic [RMW-1:0] drem1 [NB+1];
  logic [RMW-1:0] drem2 [NB+1];
  logic [NB-1:0]  dq1 [NB+1];
  logic [NB-1:0]  dq2 [NB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= sv[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dside[0] <= side_p;
      ddm[0]   <= dm_p;
      dnum1[0] <= {n1m[MW-1:0], {FRAC_BITS{1'b0}}};
      dnum2[0] <= {n2m[MW-1:0], {FRAC_BITS{1'b0}}};
      drem1[0] <= '0;
      drem2[0] <= '0;
      dq1[0]   <= '0;
      dq2[0]   <= '0;
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_div
    qrs_div_cell #(.NB(NB), .RMW(RMW), .DMW(DMW)) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .v_in(dv[j]), .side_in(dside[j]), .dm_in(ddm[j]),
      .num1_in(dnum1[j]), .num2_in(dnum2[j]), .rem1_in(drem1[j]), .rem2_in(drem2[j]),
      .q1_in(dq1[j]), .q2_in(dq2[j]),
      .v_out(dv[j+1]), .side_out(dside[j+1]), .dm_out(ddm[j+1]),
      .num1_out(dnum1[j+1]), .num2_out(dnum2[j+1]),
      .rem1_out(drem1[j+1]), .rem2_out(drem2[j+1]),
      .q1_out(dq1[j+1]), .q2_out(dq2[j+1])
    );
  end

  // saturation, sign and snapping
  qrs_side_t     sf;
  logic [NB-1:0] ql [2];
  logic          nl [2], zl [2], negl [2], overl [2];
  logic [W-1:0]  lim [2], qm [2], xl [2];
  qrs_root_t     root_c;

  always_comb begin
    sf      = dside[NB];
    ql[0]   = dq1[NB];
    ql[1]   = dq2[NB];
    nl[0]   = sf.neg1;
    nl[1]   = sf.neg2;
    zl[0]   = sf.nz1;
    zl[1]   = sf.nz2;
    for (int l = 0; l < 2; l++) begin
      negl[l]  = sf.dz ? nl[l] : (nl[l] ^ sf.dsign);
      lim[l]   = negl[l] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      overl[l] = zl[l] && (ql[l] > {{(NB-W){1'b0}}, lim[l]});
      qm[l]    = !zl[l] ? '0 : (overl[l] ? lim[l] : ql[l][W-1:0]);
      if (qm[l] <= {{(W-31){1'b0}}, root_eps}) begin
        xl[l] = '0;
      end else begin
        xl[l] = negl[l] ? (~qm[l] + 1'b1) : qm[l];
      end
    end
    root_c.root_kind = sf.kind;
    root_c.root_low  = sf.div_on ? xl[0] : '0;
    root_c.root_high = sf.div_on ? xl[1] : '0;
    root_c.overflow  = sf.div_on && (overl[0] || overl[1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_valid <= 1'b0;
    end else if (adv) begin
      root_valid <= dv[NB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      root <= root_c;
    end
  end

endmodule

// ===== hw/rtl/qrs_checker.sv =====
// quadratic root solver: port-level checks over time, bound to the top level
// depends on qrs_pkg and quadratic_root_solver_core
`timescale 1ns / 1ps
module qrs_checker (
  input logic               clk,
  input logic               rst,
  input logic               coef_valid,
  input logic               coef_ready,
  input qrs_pkg::qrs_coef_t coef,
  input logic               root_valid,
  input logic               root_ready,
  input qrs_pkg::qrs_root_t root,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [4:0]         paddr,
  input logic [63:0]        pwdata,
  input logic [63:0]        prdata,
  input logic               pready
);
  import qrs_pkg::*;

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    root_valid && !root_ready |=> root_valid && $stable(root))
    else $error("root word changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !root_valid)
    else $error("root word after reset");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    root_valid && (root.root_kind == KIND_NONE || root.root_kind == KIND_INFINITE)
    |-> root.root_low == '0 && root.root_high == '0 && !root.overflow)
    else $error("roots present without a root");

  a_single: assert property (@(posedge clk) disable iff (rst)
    root_valid && root.root_kind == KIND_ONE |-> root.root_low == root.root_high)
    else $error("single root differs between lanes");

  // stall backs up to the input side
  a_stall: assert property (@(posedge clk) disable iff (rst)
    root_valid && !root_ready |-> !coef_ready)
    else $error("input taken while output stalled");

endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (.*);

// ===== tb/sv/quadratic_root_solver_core_test.sv =====
// testbench for quadratic_root_solver_core: random and directed coefficient words,
// in-bench root predictor, apb register phases, bursty sender and stalling receiver
// depends on qrs_pkg and quadratic_root_solver_core
`timescale 1ns / 1ps
module quadratic_root_solver_core_test;
  import qrs_pkg::*;

  localparam longint unsigned POS_SAT = 64'h7fffffff;
  localparam longint unsigned NEG_SAT = 64'h80000000;
  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic coef_valid = 1'b0;
  logic coef_ready;
  qrs_coef_t coef = '0;
  logic root_valid;
  logic root_ready = 1'b0;
  qrs_root_t root;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  quadratic_root_solver_core dut (
    .clk(clk), .rst(rst),
    .coef_valid(coef_valid), .coef_ready(coef_ready), .coef(coef),
    .root_valid(root_valid), .root_ready(root_ready), .root(root),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  longint unsigned coeff_eps = 1;
  longint unsigned disc_eps = 1;
  longint unsigned root_eps = 0;

  qrs_coef_t pending_coefs[$];
  qrs_root_t expected_roots[$];
  int errors = 0;
  int cycles = 0;
  bit hold_req = 1'b0;

  function automatic void split_coef(input logic [31:0] raw, output longint unsigned mag,
                                     output bit neg);
    longint sx;
    sx = longint'($signed(raw));
    neg = raw[31];
    mag = neg ? longint'(-sx) : sx;
  endfunction

  function automatic logic [31:0] fixed_div(input longint unsigned nmag, input bit nneg,
                                            input longint unsigned dmag, input bit dneg,
                                            inout bit ovf);
    bit neg;
    bit big;
    logic [127:0] q;
    longint unsigned lim;
    longint unsigned qmag;
    if (nmag == 0) return '0;
    neg = nneg != dneg;
    big = 1'b0;
    q = '0;
    if (dmag == 0) begin
      neg = nneg;
      big = 1'b1;
    end else begin
      q = {64'd0, nmag} << QRS_FRAC_BITS;
      q = q / {64'd0, dmag};
    end
    lim = neg ? NEG_SAT : POS_SAT;
    if (big || q > {64'd0, lim}) begin
      qmag = lim;
      ovf = 1'b1;
    end else begin
      qmag = q[63:0];
    end
    return neg ? 32'(-qmag) : 32'(qmag);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [127:0] d);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int k = 40; k >= 0; k--) begin
      c = r | (128'd1 << k);
      if (c * c <= d) r = c;
    end
    return r[63:0];
  endfunction

  function automatic logic [31:0] snap_root(input logic [31:0] x);
    longint unsigned m;
    bit n;
    split_coef(x, m, n);
    return (m <= root_eps) ? '0 : x;
  endfunction

  function automatic qrs_root_t solve_roots(input qrs_coef_t w);
    qrs_root_t r;
    longint unsigned am, bm, cm, m1, m2;
    bit an, bn, cn, dneg, ovf;
    logic [127:0] bb, ac4, d;
    longint s, bv, n1, n2;
    logic [31:0] x1, x2;
    logic [1:0] kind;
    split_coef(w.coef_quad, am, an);
    split_coef(w.coef_lin, bm, bn);
    split_coef(w.coef_const, cm, cn);
    ovf = 1'b0;
    x1 = '0;
    x2 = '0;
    kind = KIND_NONE;
    if (am < coeff_eps) begin
      if (bm < coeff_eps) begin
        kind = (cm < coeff_eps) ? KIND_INFINITE : KIND_NONE;
      end else begin
        x1 = fixed_div(cm, !cn, bm, bn, ovf);
        x2 = x1;
        kind = KIND_ONE;
      end
    end else begin
      bb = {64'd0, bm} * {64'd0, bm};
      ac4 = ({64'd0, am} * {64'd0, cm}) << 2;
      dneg = 1'b0;
      if (an != cn) begin
        d = bb + ac4;
      end else if (bb >= ac4) begin
        d = bb - ac4;
      end else begin
        d = ac4 - bb;
        dneg = 1'b1;
      end
      if (d <= {64'd0, disc_eps}) begin
        x1 = fixed_div(bm, !bn, am << 1, an, ovf);
        x2 = x1;
        kind = KIND_ONE;
      end else if (!dneg) begin
        s = longint'(floor_sqrt(d));
        bv = bn ? -longint'(bm) : longint'(bm);
        n1 = -bv - s;
        n2 = -bv + s;
        m1 = n1 < 0 ? -n1 : n1;
        m2 = n2 < 0 ? -n2 : n2;
        x1 = fixed_div(m1, n1 < 0, am << 1, an, ovf);
        x2 = fixed_div(m2, n2 < 0, am << 1, an, ovf);
        kind = KIND_TWO;
      end
    end
    r.root_kind = kind;
    r.root_low = snap_root(x1);
    r.root_high = snap_root(x2);
    r.overflow = ovf;
    return r;
  endfunction

  // sender: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      coef_valid <= 1'b0;
    end else if (!coef_valid || coef_ready) begin
      if (coef_valid) expected_roots.push_back(solve_roots(coef));
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        coef_valid <= 1'b0;
      end else if (pending_coefs.size() > 0) begin
        coef <= pending_coefs.pop_front();
        coef_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 60);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        coef_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern plus one long hold-off on request
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  qrs_root_t want;
  always @(posedge clk) begin
    if (rst) begin
      root_ready <= 1'b0;
    end else begin
      if (root_valid && root_ready) begin
        if (expected_roots.size() == 0) begin
          $error("unexpected root word %h", root);
          errors++;
        end else begin
          want = expected_roots.pop_front();
          if (root.root_kind !== want.root_kind) begin
            $error("root_kind expected %0d got %0d", want.root_kind, root.root_kind);
            errors++;
          end
          if (root.root_low !== want.root_low) begin
            $error("root_low expected %h got %h", want.root_low, root.root_low);
            errors++;
          end
          if (root.root_high !== want.root_high) begin
            $error("root_high expected %h got %h", want.root_high, root.root_high);
            errors++;
          end
          if (root.overflow !== want.overflow) begin
            $error("overflow expected %0d got %0d", want.overflow, root.overflow);
            errors++;
          end
        end
      end
      if (hold_req && !hold_done && hold_left == 0) begin
        hold_left <= 500;
        hold_done <= 1'b1;
        root_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        root_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode <= $urandom_range(0, 3);
          mode_left <= $urandom_range(8, 120);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          0: begin
            root_ready <= 1'b1;
          end
          1: begin
            root_ready <= $urandom_range(0, 1);
          end
          2: begin
            root_ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            root_ready <= ($urandom_range(0, 7) != 0);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("quadratic_root_solver_core_test: errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_COEFF_EPS: coeff_eps = value & 64'h7fffffff;
      REG_DISC_EPS: disc_eps = value & 64'h3fffffffffffffff;
      REG_ROOT_EPS: root_eps = value & 64'h7fffffff;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_coefs.size() != 0 || coef_valid || expected_roots.size() != 0);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coef();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = 32'h7fffffff;
      2: v = 32'h80000000;
      3, 4: v = $urandom;
      5, 6: v = ($urandom_range(0, 20) << 16) | $urandom_range(0, 16'hffff);
      7: v = $urandom_range(0, 4);
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 1) && v != 32'h80000000) v = -v;
    return v;
  endfunction

  task automatic push_coef(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
    qrs_coef_t w;
    w.coef_quad = a;
    w.coef_lin = b;
    w.coef_const = c;
    pending_coefs.push_back(w);
  endtask

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) push_coef(pick_coef(), pick_coef(), pick_coef());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // directed words at reset register values
    push_coef(0, 0, 0);
    push_coef(0, 0, 5 << 16);
    push_coef(0, 2 << 16, -(4 << 16));
    push_coef(0, 1, 32'h7fffffff);
    push_coef(1 << 16, 0, -(4 << 16));
    push_coef(1 << 16, 2 << 16, 1 << 16);
    push_coef(1 << 16, 0, 1 << 16);
    push_coef(-(2 << 16), 3 << 16, 5 << 16);
    push_coef(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    push_coef(32'h80000000, 32'h80000000, 32'h80000000);
    push_coef(32'h80000000, 32'h7fffffff, 32'h80000000);
    push_coef(1, 32'h80000000, 0);
    push_coef(1, 32'h7fffffff, 32'h80000000);
    push_coef(32'h7fffffff, 1, 1);
    push_coef(32'hffffffff, 32'hffffffff, 32'hffffffff);
    push_coef(1 << 16, -(5 << 16), 6 << 16);
    push_random(300);
    hold_req = 1'b1;
    wait_idle();
    // zero tolerances: zero divisors reach the divider
    write_reg(REG_COEFF_EPS, 64'h0);
    write_reg(REG_DISC_EPS, 64'h0);
    write_reg(REG_ROOT_EPS, 64'h0);
    push_coef(0, 0, 0);
    push_coef(0, 0, 3 << 16);
    push_coef(0, 3 << 16, 1 << 16);
    push_coef(0, -(3 << 16), -(1 << 16));
    push_coef(1 << 16, 2 << 16, 1 << 16);
    push_random(320);
    wait_idle();
    // widest tolerances with upper bits set
    write_reg(REG_COEFF_EPS, 64'hffffffffffffffff);
    write_reg(REG_DISC_EPS, 64'hffffffffffffffff);
    write_reg(REG_ROOT_EPS, 64'hffffffffffffffff);
    push_random(150);
    wait_idle();
    write_reg(REG_COEFF_EPS, 64'h0);
    write_reg(REG_ROOT_EPS, 64'h7fffffff);
    push_random(150);
    wait_idle();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_COEFF_EPS, {$urandom, $urandom} >> $urandom_range(38, 63));
      write_reg(REG_DISC_EPS, {$urandom, $urandom} >> $urandom_range(10, 63));
      write_reg(REG_ROOT_EPS, {$urandom, $urandom} >> $urandom_range(40, 63));
      push_random(260);
      wait_idle();
    end
    if (errors == 0) begin
      $display("quadratic_root_solver_core_test: clean");
    end else begin
      $display("quadratic_root_solver_core_test: errors");
    end
    $finish;
  end

endmodule
